@@ sv/vrt_pkg.sv @@
// Package for the voxel ray traversal core: result kinds, state codes, result type.
// No dependencies.
package vrt_pkg;

    localparam logic [31:0] T_INF = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        KIND_QUERY = 2'd0,
        KIND_HIT   = 2'd1,
        KIND_MISS  = 2'd2,
        KIND_IDLE  = 2'd3
    } kind_t;

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_SQ   = 9'b000000010,
        ST_SQRT = 9'b000000100,
        ST_DSET = 9'b000001000,
        ST_DIV  = 9'b000010000,
        ST_MUL  = 9'b000100000,
        ST_ADV  = 9'b001000000,
        ST_WALK = 9'b010000000,
        ST_EMIT = 9'b100000000
    } state_t;

    typedef struct packed {
        kind_t            kind;
        logic [2:0][15:0] place;
        logic [2:0][15:0] voxel;
    } res_t;

endpackage

@@ sv/voxel_ray_traversal_core.sv @@
// Voxel ray traversal core: ray setup (norm, square root, reciprocal spacing) and
// grid walk on one shared multiplier, root/divide stepper and walk step.
// Depends on vrt_pkg.
// A start item runs the squares, the root, a divide and a multiply per axis, then the
// walk; a non-solid reply advances a cell and walks on. The 32-step root and divide
// iterations are the longest part of the setup; one item is worked at a time.
// Reset (rst_n low, async): no active ray, max_reach = 8.0, output empty.
module voxel_ray_traversal_core #(
    parameter int HEIGHT_LIMIT = 256
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, block_solid, 7 zero bits
    input  logic [151:0] s_tdata,
    // mode
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // cell_x, cell_y, cell_z, place_x, place_y, place_z
    output logic [95:0]  m_tdata,
    // kind
    output logic [1:0]   m_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    vrt_pkg::state_t state_reg, state_next;
    logic [30:0] max_reach_reg;
    logic active_reg, active_next;
    logic [2:0][15:0] cur_reg, cur_next, prev_reg, prev_next, frac_reg, frac_next;
    logic [2:0][1:0] sign_reg, sign_next;
    logic [2:0][16:0] mag_reg, mag_next;
    logic [2:0][31:0] nc_reg, nc_next, sp_reg, sp_next;
    logic [31:0] trav_reg, trav_next;
    logic [1:0] axis_reg, axis_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [31:0] s_reg, s_next, root_reg, root_next, q_reg, q_next;
    logic [33:0] rem_reg, rem_next;
    logic [16:0] drem_reg, drem_next;
    vrt_pkg::res_t res_reg, res_next, out_reg, out_next;
    logic out_valid_reg, out_valid_next;

    logic [16:0] mul_a;
    logic [31:0] mul_b;
    logic [48:0] mul_p;
    logic [35:0] sq_sh, sq_trial;
    logic [17:0] dv_sh;
    logic [1:0] adv_axis;
    logic [32:0] adv_sum, pr_hi;
    logic [16:0] cross_dist;
    logic [2:0][15:0] in_dir;
    logic in_acc;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {1'b0, max_reach_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reach_reg <= 31'd524288;
        end
        else if (psel && penable && pwrite && !paddr[2])
        begin
            max_reach_reg <= pwdata[30:0];
        end
    end

    assign s_tready = (state_reg == vrt_pkg::ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {out_reg.place, out_reg.voxel};
    assign in_dir   = s_tdata[143:96];

    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        if (state_reg == vrt_pkg::ST_SQ)
        begin
            mul_a = mag_reg[axis_reg];
            mul_b = {15'd0, mag_reg[axis_reg]};
        end
        else
        begin
            mul_a = cross_dist;
            mul_b = sp_reg[axis_reg];
        end
    end

    assign cross_dist = (sign_reg[axis_reg] == 2'b01) ? (17'h10000 - {1'b0, frac_reg[axis_reg]})
                                                      : {1'b0, frac_reg[axis_reg]};
    assign pr_hi    = mul_p[48:16];
    assign sq_sh    = {rem_reg, s_reg[31:30]};
    assign sq_trial = {2'b00, root_reg, 2'b01};
    assign dv_sh    = {drem_reg, q_reg[31]};

    always_comb
    begin
        if (nc_reg[0] < nc_reg[1])
        begin
            adv_axis = (nc_reg[0] < nc_reg[2]) ? 2'd0 : 2'd2;
        end
        else
        begin
            adv_axis = (nc_reg[1] < nc_reg[2]) ? 2'd1 : 2'd2;
        end
    end
    assign adv_sum = {1'b0, nc_reg[adv_axis]} + {1'b0, sp_reg[adv_axis]};

    always_comb
    begin
        state_next     = state_reg;
        active_next    = active_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        frac_next      = frac_reg;
        sign_next      = sign_reg;
        mag_next       = mag_reg;
        nc_next        = nc_reg;
        sp_next        = sp_reg;
        trav_next      = trav_reg;
        axis_next      = axis_reg;
        cnt_next       = cnt_reg;
        s_next         = s_reg;
        root_next      = root_reg;
        rem_next       = rem_reg;
        q_next         = q_reg;
        drem_next      = drem_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            vrt_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    res_next  = '0;
                    state_next = vrt_pkg::ST_EMIT;
                    if (!s_tuser)
                    begin
                        active_next = 1'b0;
                        for (int a = 0; a < 3; a++)
                        begin
                            sign_next[a] = (in_dir[a] == 16'd0) ? 2'b00 :
                                           (in_dir[a][15] ? 2'b11 : 2'b01);
                            mag_next[a]  = in_dir[a][15] ? (17'h10000 - {1'b0, in_dir[a]})
                                                         : {1'b0, in_dir[a]};
                        end
                        if (in_dir == '0)
                        begin
                            res_next.kind = vrt_pkg::KIND_MISS;
                        end
                        else
                        begin
                            for (int a = 0; a < 3; a++)
                            begin
                                cur_next[a]  = s_tdata[32*a+16 +: 16];
                                frac_next[a] = s_tdata[32*a +: 16];
                            end
                            prev_next  = cur_next;
                            s_next     = '0;
                            axis_next  = 2'd0;
                            state_next = vrt_pkg::ST_SQ;
                        end
                    end
                    else if (!active_reg)
                    begin
                        res_next.kind = vrt_pkg::KIND_IDLE;
                    end
                    else if (s_tdata[144])
                    begin
                        active_next    = 1'b0;
                        res_next.kind  = vrt_pkg::KIND_HIT;
                        res_next.voxel = cur_reg;
                        res_next.place = prev_reg;
                    end
                    else
                    begin
                        state_next = vrt_pkg::ST_ADV;
                    end
                end
            end
            vrt_pkg::ST_SQ:
            begin
                s_next = s_reg + mul_p[31:0];
                if (axis_reg == 2'd2)
                begin
                    rem_next   = '0;
                    root_next  = '0;
                    cnt_next   = 5'd31;
                    state_next = vrt_pkg::ST_SQRT;
                end
                else
                begin
                    axis_next = axis_reg + 2'd1;
                end
            end
            vrt_pkg::ST_SQRT:
            begin
                s_next = {s_reg[29:0], 2'b00};
                if (sq_sh >= sq_trial)
                begin
                    rem_next  = 34'(sq_sh - sq_trial);
                    root_next = {root_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next  = sq_sh[33:0];
                    root_next = {root_reg[30:0], 1'b0};
                end
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    axis_next  = 2'd0;
                    state_next = vrt_pkg::ST_DSET;
                end
            end
            vrt_pkg::ST_DSET:
            begin
                if (mag_reg[axis_reg] == 17'd0)
                begin
                    sp_next[axis_reg] = vrt_pkg::T_INF;
                    nc_next[axis_reg] = vrt_pkg::T_INF;
                    if (axis_reg == 2'd2)
                    begin
                        axis_next  = 2'd0;
                        state_next = vrt_pkg::ST_MUL;
                    end
                    else
                    begin
                        axis_next = axis_reg + 2'd1;
                    end
                end
                else
                begin
                    q_next     = root_reg;
                    drem_next  = '0;
                    cnt_next   = 5'd31;
                    state_next = vrt_pkg::ST_DIV;
                end
            end
            vrt_pkg::ST_DIV:
            begin
                if (dv_sh >= {1'b0, mag_reg[axis_reg]})
                begin
                    drem_next = 17'(dv_sh - {1'b0, mag_reg[axis_reg]});
                    q_next    = {q_reg[30:0], 1'b1};
                end
                else
                begin
                    drem_next = dv_sh[16:0];
                    q_next    = {q_reg[30:0], 1'b0};
                end
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    sp_next[axis_reg] = q_next;
                    if (axis_reg == 2'd2)
                    begin
                        axis_next  = 2'd0;
                        state_next = vrt_pkg::ST_MUL;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = vrt_pkg::ST_DSET;
                    end
                end
            end
            vrt_pkg::ST_MUL:
            begin
                if (mag_reg[axis_reg] != 17'd0)
                begin
                    nc_next[axis_reg] = pr_hi[32] ? vrt_pkg::T_INF : pr_hi[31:0];
                end
                if (axis_reg == 2'd2)
                begin
                    trav_next  = '0;
                    state_next = vrt_pkg::ST_WALK;
                end
                else
                begin
                    axis_next = axis_reg + 2'd1;
                end
            end
            vrt_pkg::ST_ADV, vrt_pkg::ST_WALK:
            begin
                if (state_reg == vrt_pkg::ST_WALK && trav_reg > {1'b0, max_reach_reg})
                begin
                    active_next   = 1'b0;
                    res_next      = '0;
                    res_next.kind = vrt_pkg::KIND_MISS;
                    state_next    = vrt_pkg::ST_EMIT;
                end
                else if (state_reg == vrt_pkg::ST_WALK && cur_reg[1] < 16'(HEIGHT_LIMIT))
                begin
                    active_next    = 1'b1;
                    res_next       = '0;
                    res_next.kind  = vrt_pkg::KIND_QUERY;
                    res_next.voxel = cur_reg;
                    state_next     = vrt_pkg::ST_EMIT;
                end
                else
                begin
                    prev_next          = cur_reg;
                    cur_next[adv_axis] = cur_reg[adv_axis]
                                       + {{14{sign_reg[adv_axis][1]}}, sign_reg[adv_axis]};
                    trav_next          = nc_reg[adv_axis];
                    nc_next[adv_axis]  = adv_sum[32] ? vrt_pkg::T_INF : adv_sum[31:0];
                    state_next         = vrt_pkg::ST_WALK;
                end
            end
            vrt_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = vrt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = vrt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= vrt_pkg::ST_IDLE;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        prev_reg <= prev_next;
        frac_reg <= frac_next;
        sign_reg <= sign_next;
        mag_reg  <= mag_next;
        nc_reg   <= nc_next;
        sp_reg   <= sp_next;
        trav_reg <= trav_next;
        axis_reg <= axis_next;
        cnt_reg  <= cnt_next;
        s_reg    <= s_next;
        root_reg <= root_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        drem_reg <= drem_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == vrt_pkg::ST_DIV) |-> (mag_reg[axis_reg] != 17'd0))
        else $error("divide step with zero divisor");

    a_miss_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == vrt_pkg::KIND_MISS) |-> (m_tdata == '0))
        else $error("miss item carries cell data");

    a_setup_inactive: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == vrt_pkg::ST_SQRT || state_reg == vrt_pkg::ST_DIV) |-> !active_reg)
        else $error("ray active during setup");

endmodule

@@ tb/voxel_ray_traversal_checker.sv @@
// Checker for the voxel ray traversal core: watches the item, result and APB channels,
// predicts each result from its own copy of the walk state and compares in order.
// Depends on vrt_pkg.
module voxel_ray_traversal_checker #(
    parameter int HEIGHT_LIMIT = 256
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [151:0] s_tdata,
    input  logic         s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [95:0]  m_tdata,
    input  logic [1:0]   m_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    input  logic         pready,
    output int           errors,
    output int           pending,
    output bit           ray_live
);

    logic [30:0]   reach;
    logic [15:0]   cur [3];
    logic [15:0]   prv [3];
    int            sgn [3];
    logic [31:0]   nxt [3];
    logic [31:0]   spc [3];
    logic [31:0]   trav;
    vrt_pkg::res_t expected_q [$];

    function automatic logic [63:0] root64(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = a + b;
        return s[32] ? vrt_pkg::T_INF : s[31:0];
    endfunction

    function automatic vrt_pkg::res_t make_res(vrt_pkg::kind_t k, bit with_cell,
                                               bit with_place);
        vrt_pkg::res_t r;
        r = '0;
        r.kind = k;
        for (int i = 0; i < 3; i++)
        begin
            if (with_cell)
                r.voxel[i] = cur[i];
            if (with_place)
                r.place[i] = prv[i];
        end
        return r;
    endfunction

    task automatic advance_cell();
        int a;
        for (int i = 0; i < 3; i++)
            prv[i] = cur[i];
        if (nxt[0] < nxt[1])
            a = (nxt[0] < nxt[2]) ? 0 : 2;
        else
            a = (nxt[1] < nxt[2]) ? 1 : 2;
        cur[a] = cur[a] + 16'(sgn[a]);
        trav = nxt[a];
        nxt[a] = sat_add(nxt[a], spc[a]);
    endtask

    task automatic walk_cells(output vrt_pkg::res_t r);
        forever
        begin
            if (trav > {1'b0, reach})
            begin
                ray_live = 0;
                r = make_res(vrt_pkg::KIND_MISS, 0, 0);
                return;
            end
            if (cur[1] < HEIGHT_LIMIT)
            begin
                ray_live = 1;
                r = make_res(vrt_pkg::KIND_QUERY, 1, 0);
                return;
            end
            advance_cell();
        end
    endtask

    task automatic trace_item(bit mode, logic [151:0] d, output vrt_pkg::res_t r);
        logic [16:0] mag [3];
        logic [15:0] raw;
        logic [63:0] s;
        logic [63:0] len;
        logic [63:0] sp;
        logic [63:0] cross_dist;
        logic [63:0] prod;
        logic [31:0] o;
        if (mode)
        begin
            if (!ray_live)
                r = make_res(vrt_pkg::KIND_IDLE, 0, 0);
            else if (d[144])
            begin
                ray_live = 0;
                r = make_res(vrt_pkg::KIND_HIT, 1, 1);
            end
            else
            begin
                advance_cell();
                walk_cells(r);
            end
            return;
        end
        s = 0;
        for (int a = 0; a < 3; a++)
        begin
            raw = d[96 + 16*a +: 16];
            mag[a] = raw[15] ? 17'h10000 - raw : {1'b0, raw};
            sgn[a] = (raw == 0) ? 0 : (raw[15] ? -1 : 1);
            s = s + mag[a] * mag[a];
        end
        ray_live = 0;
        if (s == 0)
        begin
            r = make_res(vrt_pkg::KIND_MISS, 0, 0);
            return;
        end
        len = root64(s << 32);
        for (int a = 0; a < 3; a++)
        begin
            o = d[32*a +: 32];
            cur[a] = o[31:16];
            prv[a] = o[31:16];
            if (mag[a] == 0)
            begin
                spc[a] = vrt_pkg::T_INF;
                nxt[a] = vrt_pkg::T_INF;
            end
            else
            begin
                sp = len / mag[a];
                spc[a] = (sp > vrt_pkg::T_INF) ? vrt_pkg::T_INF : sp[31:0];
                cross_dist = (sgn[a] > 0) ? 64'h10000 - o[15:0] : 64'(o[15:0]);
                prod = (cross_dist * spc[a]) >> 16;
                nxt[a] = (prod > vrt_pkg::T_INF) ? vrt_pkg::T_INF : prod[31:0];
            end
        end
        trav = 0;
        walk_cells(r);
    endtask

    always @(posedge clk)
    begin
        vrt_pkg::res_t got;
        vrt_pkg::res_t want;
        bit   bad;
        if (!rst_n)
        begin
            reach = 31'd524288;
            ray_live = 0;
            for (int i = 0; i < 3; i++)
            begin
                cur[i] = 0;
                prv[i] = 0;
                sgn[i] = 0;
                nxt[i] = 0;
                spc[i] = 0;
            end
            trav = 0;
            expected_q.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.kind = vrt_pkg::kind_t'(m_tuser);
                {got.place, got.voxel} = m_tdata;
                if (expected_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result kind %0d data %h", m_tuser, m_tdata);
                end
                else
                begin
                    want = expected_q.pop_front();
                    bad = (got.kind != want.kind);
                    for (int i = 0; i < 3; i++)
                        bad |= (got.voxel[i] != want.voxel[i]) ||
                               (got.place[i] != want.place[i]);
                    if (bad)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: kind %0d/%0d cell %h/%h place %h/%h (exp/got)",
                                     want.kind, got.kind, want.voxel, got.voxel,
                                     want.place, got.place);
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                trace_item(s_tuser, s_tdata, want);
                expected_q.push_back(want);
            end
            if (psel && penable && pwrite && pready && paddr == 3'd0)
                reach = pwdata[30:0];
        end
        pending = expected_q.size();
    end

endmodule

@@ tb/voxel_ray_traversal_core_tb.sv @@
// Testbench top for the voxel ray traversal core: clock, reset, ray and reply
// stimulus, APB reach writes and the verdict. Depends on vrt_pkg and the checker.
module voxel_ray_traversal_core_tb;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [151:0] s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [95:0]  m_tdata;
    logic [1:0]   m_tuser;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;
    int           errors;
    int           pending;
    bit           ray_live;
    int           tx_idle_pct;
    int           rx_stall_pct;
    bit           flat_rays;

    voxel_ray_traversal_core DUT (.*);

    voxel_ray_traversal_checker u_checker (.*);

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(negedge clk)
        m_tready = ($urandom_range(0, 99) >= rx_stall_pct);

    task automatic send(bit mode, logic [151:0] d);
        @(negedge clk);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid = 0;
            @(negedge clk);
        end
        s_tvalid = 1;
        s_tuser = mode;
        s_tdata = d;
        forever
        begin
            @(posedge clk);
            if (s_tready)
                break;
        end
    endtask

    task automatic start_ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                             logic [15:0] dx, logic [15:0] dy, logic [15:0] dz);
        send(1'b0, {7'd0, 1'($urandom), dz, dy, dx, oz, oy, ox});
    endtask

    task automatic reply(bit solid);
        logic [151:0] d;
        d = 152'({$urandom, $urandom, $urandom, $urandom, $urandom});
        d[151:145] = 0;
        d[144] = solid;
        send(1'b1, d);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid = 0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic write_reach(logic [31:0] v);
        wait_drained();
        repeat (200) @(negedge clk);
        psel = 1;
        pwrite = 1;
        paddr = 3'd0;
        pwdata = v;
        @(negedge clk);
        penable = 1;
        @(negedge clk);
        psel = 0;
        penable = 0;
        pwrite = 0;
    endtask

    function automatic logic [15:0] rand_dir();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
            2: return 16'($urandom_range(0, 8)) - 16'd4;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rand_coord(bit height);
        logic [31:0] v;
        if (!flat_rays && $urandom_range(0, 9) == 0)
            return $urandom;
        v[15:0] = 16'($urandom);
        v[31:16] = height ? 16'($urandom_range(0, 263)) - 16'd4
                          : 16'($urandom_range(0, 40)) - 16'd20;
        if (flat_rays && height)
            v[31:16] = 16'($urandom_range(0, 255));
        return v;
    endfunction

    task automatic random_item();
        if ($urandom_range(0, 4) != 0)
        begin
            wait_drained();
            if (ray_live && $urandom_range(0, 19) != 0)
            begin
                reply($urandom_range(0, 99) < 15);
                return;
            end
        end
        else if ($urandom_range(0, 1))
        begin
            reply($urandom_range(0, 1));
            return;
        end
        start_ray(rand_coord(0), rand_coord(1), rand_coord(0),
                  rand_dir(), flat_rays ? 16'h0000 : rand_dir(), rand_dir());
    endtask

    initial
    begin
        int n;
        rst_n = 0;
        s_tvalid = 0;
        s_tuser = 0;
        s_tdata = '0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = 0;
        pwdata = 0;
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        flat_rays = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed
        reply(1);
        start_ray(32'h0001_8000, 32'h0010_0000, 32'h0, 16'h0, 16'h0, 16'h0);
        start_ray(32'h0000_8000, 32'h0005_8000, 32'h0000_8000, 16'h4000, 16'h0, 16'h0);
        reply(1);
        start_ray(32'h0, 32'h0005_0000, 32'h0, 16'h2000, 16'h2000, 16'h2000);
        reply(0);
        reply(0);
        reply(0);
        start_ray(32'h0003_4000, 32'h0006_c000, 32'hFFFF_0000, 16'hC000, 16'h3000, 16'h1000);
        reply(0);
        start_ray(32'h0, 32'hFFFB_0000, 32'h0, 16'h0100, 16'h4000, 16'h0);
        reply(0);
        start_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h8000, 16'h8000, 16'h8000);
        start_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        start_ray(32'h0, 32'h012C_0000, 32'h0, 16'h0, 16'h4000, 16'h0);
        reply(0);
        start_ray(32'h7FFF_0000, 32'h0000_0000, 32'h0, 16'h4000, 16'h0, 16'h0);
        reply(0);
        reply(0);
        reply(1);
        reply(0);

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                1: write_reach(32'h0);
                2: write_reach(32'h0000_0000 | $urandom_range(1, 40 << 16));
                3: write_reach(32'hFFFF_FFFF);
                4: write_reach(32'h8014_0000);
                5: write_reach(32'h0000_0000 | $urandom_range(1 << 16, 64 << 16));
                default: ;
            endcase
            flat_rays = (ph == 3);
            n = (ph == 3) ? 60 : 270;
            for (int i = 0; i < n; i++)
            begin
                case ((i * 4) / n)
                    0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                    1: begin tx_idle_pct = 71; rx_stall_pct = 0;  end
                    2: begin tx_idle_pct = 0;  rx_stall_pct = 71; end
                    default: begin tx_idle_pct = 18; rx_stall_pct = 18; end
                endcase
                random_item();
            end
        end

        wait_drained();
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #100_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
sv/vrt_pkg.sv
sv/voxel_ray_traversal_core.sv
tb/voxel_ray_traversal_checker.sv
tb/voxel_ray_traversal_core_tb.sv
